// ----- hdl/spd_pkg.sv -----
// Package for the signaling payload deframer: message kinds, routes, field tags,
// frame magic words and the queued result-group type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package spd_pkg;

    // Message kinds carried on the input tuser
    localparam logic [2:0] KIND_OFFER  = 3'd0;
    localparam logic [2:0] KIND_ANSWER = 3'd1;
    localparam logic [2:0] KIND_RENEG  = 3'd2;
    localparam logic [2:0] KIND_ICE    = 3'd3;
    localparam logic [2:0] KIND_HANGUP = 3'd4;

    // Handler routes in the verdict
    localparam logic [2:0] ROUTE_OFFER  = 3'd0;
    localparam logic [2:0] ROUTE_ANSWER = 3'd1;
    localparam logic [2:0] ROUTE_ICE    = 3'd2;
    localparam logic [2:0] ROUTE_HANGUP = 3'd3;
    localparam logic [2:0] ROUTE_NONE   = 3'd4;

    // Content field tags
    localparam logic [1:0] TAG_SDP       = 2'd0;
    localparam logic [1:0] TAG_MEDIA_ID  = 2'd1;
    localparam logic [1:0] TAG_CANDIDATE = 2'd2;

    // Result item kinds
    localparam logic ITEM_CONTENT = 1'b0;
    localparam logic ITEM_VERDICT = 1'b1;

    // Verdict status
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // Frame magic words, first byte in the top bits
    localparam logic [31:0] MAGIC_SDP = 32'h5753_4450;  // "WSDP"
    localparam logic [31:0] MAGIC_ICE = 32'h5749_4345;  // "WICE"
    localparam logic [31:0] MAGIC_HUP = 32'h5748_5550;  // "WHUP"

    localparam logic [7:0] VERSION_BYTE = 8'd1;

    // Register reset values and field widths
    localparam int SDP_LIMIT_W        = 17;
    localparam int CAND_LIMIT_W       = 11;
    localparam logic [16:0] SDP_LIMIT_RST  = 17'd65536;
    localparam logic [10:0] CAND_LIMIT_RST = 11'd1024;

    localparam int POSITION_BITS_DEF = 18;

    // Configuration register indexes
    localparam logic CFG_SDP_LIMIT  = 1'b0;
    localparam logic CFG_CAND_LIMIT = 1'b1;

    // Results caused by one input item: an optional content byte and an
    // optional verdict
    typedef struct packed {
        logic        has_content;
        logic [1:0]  tag;
        logic [7:0]  content;
        logic        has_verdict;
        logic        status;
        logic [2:0]  route;
        logic [31:0] line_index;
    } res_group_t;

    // Pick byte idx (0 = first on the wire) of a magic word
    function automatic logic [7:0] magic_byte(input logic [31:0] word,
                                              input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = word[31:24];
            2'd1:    b = word[23:16];
            2'd2:    b = word[15:8];
            default: b = word[7:0];
        endcase
        return b;
    endfunction

    // Place a byte at byte lane k of a little-endian word
    function automatic logic [31:0] lane_byte(input logic [7:0] b,
                                              input logic [1:0] k);
        logic [31:0] w;
        case (k)
            2'd0:    w = {24'd0, b};
            2'd1:    w = {16'd0, b, 8'd0};
            2'd2:    w = {8'd0, b, 16'd0};
            default: w = {b, 24'd0};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/signaling_payload_deframer_core.sv -----
// Signaling payload deframer: per-byte frame checks and string streaming.
// Uses spd_pkg for codes, magic words and the result-group type.
//
// Usage:
//   Input items on s_* carry one payload byte each (s_tdata[7:0]), the
//   message kind in s_tuser[2:0] (sampled on the first byte of a payload)
//   and s_tlast on the final byte. Result items on m_* are either string
//   content bytes (m_tuser[0] = 0, field tag in m_tuser[2:1]) or, for the
//   final byte, a verdict (m_tuser[0] = 1, m_tlast = 1) with status, route
//   and ICE line index in m_tdata. Downstream drops streamed bytes of a
//   payload whose verdict reports a format error.
//   Result groups are registered in a queue before they leave on m_*.
//   Throughput: one input item per cycle while the queue has room; the final
//   byte of a payload may cause two results (content and verdict) in turn.
//   Results wait in a two-group queue; s_tready drops only while that queue
//   is full, so a stalled receiver backs up the input after two groups.
//   Reset (aresetn low, synchronous) empties the queue, restarts at the
//   first byte of a payload and restores both limit registers.
//   Write the limit registers via cfg_* only while the block is idle (unchecked).
`timescale 1ns / 1ps
`default_nettype none

module signaling_payload_deframer_core
    import spd_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic [2:0]  s_tuser,   // [2:0] op
    input  wire logic        s_tlast,   // end_of_payload
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [7:0] content_byte, [8] status, [11:9] route,
                                        // [43:12] line_index, [47:44] zero
    output logic [2:0]       m_tuser,   // [0] item_kind, [2:1] field_tag
    output logic             m_tlast,   // last_result
    // configuration write port
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [16:0] cfg_wdata
);

    localparam int CW = 34;  // compare width for position vs. declared ends
    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
    localparam logic [CW-1:0] POS_MAX_X = CW'(POS_MAX);

    // Configuration registers
    logic [SDP_LIMIT_W-1:0]  sdp_limit_reg;
    logic [CAND_LIMIT_W-1:0] cand_limit_reg;

    // Per-message state
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [2:0]  kind_reg, kind_next;
    logic        err_reg, err_next;
    logic [31:0] lword_reg, lword_next;
    logic [31:0] line_reg, line_next;
    logic [7:0]  mlen_reg, mlen_next;
    logic [31:0] slen_reg, slen_next;

    // Result-group queue
    res_group_t  grp_mem [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        sub_reg;

    logic        in_fire, out_fire, push, pop, show_content;
    res_group_t  grp_new, head;

    logic [CW-1:0] ip, m_x, l_x, total;
    logic [2:0]    kind;
    logic [7:0]    b;
    logic [1:0]    k_ice;
    logic          content_v;
    logic [1:0]    content_tag;
    logic          v_status;
    logic [2:0]    v_route;
    logic [31:0]   v_line;

    assign in_fire  = s_tvalid && s_tready;
    assign s_tready = (count_reg != 2'd2);
    assign b        = s_tdata;

    // Decode one payload byte against the frame layout
    always_comb begin
        kind       = (pos_reg == '0) ? s_tuser : kind_reg;
        ip         = CW'(pos_reg);
        m_x        = CW'(mlen_reg);
        l_x        = CW'(slen_reg);
        k_ice      = 2'(ip - CW'(10) - m_x);
        kind_next  = kind;
        err_next   = err_reg;
        lword_next = lword_reg;
        line_next  = line_reg;
        mlen_next  = mlen_reg;
        slen_next  = slen_reg;
        content_v  = 1'b0;
        content_tag = TAG_SDP;

        if (kind == KIND_OFFER || kind == KIND_ANSWER || kind == KIND_RENEG) begin
            if (ip < CW'(4)) begin
                if (b != magic_byte(MAGIC_SDP, ip[1:0])) err_next = 1'b1;
            end else if (ip == CW'(4)) begin
                if (b != VERSION_BYTE) err_next = 1'b1;
            end else if (ip >= CW'(7) && ip <= CW'(10)) begin
                lword_next = lword_reg | lane_byte(b, ip[1:0] + 2'd1);
                if (ip == CW'(10)) begin
                    slen_next = lword_next;
                    if (CW'(lword_next) > CW'(sdp_limit_reg) ||
                        CW'(11) + CW'(lword_next) > POS_MAX_X) begin
                        err_next = 1'b1;
                    end
                end
            end else if (ip >= CW'(11) && ip < CW'(11) + l_x && !err_reg) begin
                content_v   = 1'b1;
                content_tag = TAG_SDP;
            end
        end else if (kind == KIND_ICE) begin
            if (ip < CW'(4)) begin
                if (b != magic_byte(MAGIC_ICE, ip[1:0])) err_next = 1'b1;
            end else if (ip == CW'(4)) begin
                if (b != VERSION_BYTE) err_next = 1'b1;
            end else if (ip >= CW'(5) && ip <= CW'(8)) begin
                line_next = line_reg | lane_byte(b, ip[1:0] - 2'd1);
            end else if (ip == CW'(9)) begin
                mlen_next = b;
            end else if (ip < CW'(10) + m_x) begin
                if (!err_reg) begin
                    content_v   = 1'b1;
                    content_tag = TAG_MEDIA_ID;
                end
            end else if (ip < CW'(14) + m_x) begin
                lword_next = lword_reg | lane_byte(b, k_ice);
                if (ip == CW'(13) + m_x) begin
                    slen_next = lword_next;
                    if (CW'(lword_next) > CW'(cand_limit_reg) ||
                        CW'(14) + m_x + CW'(lword_next) > POS_MAX_X) begin
                        err_next = 1'b1;
                    end
                end
            end else if (ip < CW'(14) + m_x + l_x && !err_reg) begin
                content_v   = 1'b1;
                content_tag = TAG_CANDIDATE;
            end
        end else if (kind == KIND_HANGUP) begin
            if (ip < CW'(4) && b != magic_byte(MAGIC_HUP, ip[1:0])) err_next = 1'b1;
        end
    end

    // Form the verdict from the state after this byte
    always_comb begin
        total    = ip + CW'(1);
        v_status = STATUS_ERR;
        v_route  = ROUTE_NONE;
        v_line   = '0;
        if (kind == KIND_OFFER || kind == KIND_ANSWER || kind == KIND_RENEG) begin
            if (!err_next && total >= CW'(11) &&
                total >= CW'(11) + CW'(slen_next)) begin
                v_status = STATUS_OK;
                v_route  = (kind == KIND_ANSWER) ? ROUTE_ANSWER : ROUTE_OFFER;
            end
        end else if (kind == KIND_ICE) begin
            if (!err_next && total >= CW'(14) + CW'(mlen_next) &&
                total >= CW'(14) + CW'(mlen_next) + CW'(slen_next)) begin
                v_status = STATUS_OK;
                v_route  = ROUTE_ICE;
                v_line   = line_next;
            end
        end else if (kind == KIND_HANGUP) begin
            v_status = STATUS_OK;
            if (!err_next && total >= CW'(5)) v_route = ROUTE_HANGUP;
        end
    end

    // Assemble the result group and the next position
    always_comb begin
        grp_new.has_content = content_v;
        grp_new.tag         = content_tag;
        grp_new.content     = b;
        grp_new.has_verdict = s_tlast;
        grp_new.status      = v_status;
        grp_new.route       = v_route;
        grp_new.line_index  = v_line;
        push = in_fire && (content_v || s_tlast);
        pos_next = (pos_reg < POS_MAX) ? pos_reg + 1'b1 : pos_reg;
    end

    // Hold config and per-message state; clear state after the final byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sdp_limit_reg  <= SDP_LIMIT_RST;
            cand_limit_reg <= CAND_LIMIT_RST;
            pos_reg   <= '0;
            kind_reg  <= '0;
            err_reg   <= 1'b0;
            lword_reg <= '0;
            line_reg  <= '0;
            mlen_reg  <= '0;
            slen_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == CFG_SDP_LIMIT) sdp_limit_reg <= cfg_wdata;
                if (cfg_index == CFG_CAND_LIMIT) cand_limit_reg <= cfg_wdata[CAND_LIMIT_W-1:0];
            end
            if (in_fire) begin
                if (s_tlast) begin
                    pos_reg   <= '0;
                    kind_reg  <= '0;
                    err_reg   <= 1'b0;
                    lword_reg <= '0;
                    line_reg  <= '0;
                    mlen_reg  <= '0;
                    slen_reg  <= '0;
                end else begin
                    pos_reg   <= pos_next;
                    kind_reg  <= kind_next;
                    err_reg   <= err_next;
                    lword_reg <= lword_next;
                    line_reg  <= line_next;
                    mlen_reg  <= mlen_next;
                    slen_reg  <= slen_next;
                end
            end
        end
    end

    // Present the head group: content byte first, then its verdict
    always_comb begin
        head         = grp_mem[rd_ptr_reg];
        show_content = head.has_content && !sub_reg;
        m_tvalid     = (count_reg != 2'd0);
        out_fire     = m_tvalid && m_tready;
        pop          = out_fire && (!show_content || !head.has_verdict);
        if (show_content) begin
            m_tuser = {head.tag, ITEM_CONTENT};
            m_tdata = {4'd0, 32'd0, ROUTE_NONE, STATUS_OK, head.content};
            m_tlast = 1'b0;
        end else begin
            m_tuser = {TAG_SDP, ITEM_VERDICT};
            m_tdata = {4'd0, head.line_index, head.route, head.status, 8'd0};
            m_tlast = 1'b1;
        end
    end

    // Write queue payload
    always_ff @(posedge aclk) begin
        if (push) grp_mem[wr_ptr_reg] <= grp_new;
    end

    // Advance queue pointers and the within-group step
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
            sub_reg    <= 1'b0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
                sub_reg    <= 1'b0;
            end else if (out_fire) begin
                sub_reg <= 1'b1;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 2'd2)
        else $error("result queue overfilled");

    a_restart_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> (pos_reg == '0 && !err_reg))
        else $error("message state not cleared after final byte");

    a_pos_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !s_tlast) |=> (pos_reg >= $past(pos_reg)))
        else $error("byte position went backward within a message");

    a_verdict_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[0] == m_tlast))
        else $error("verdict and last_result disagree");
`endif

endmodule

`default_nettype wire
